### src/priority_ready_queue_scheduler_defines.svh
// Assertion macros for the priority ready-queue scheduler
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define PRQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRQS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PRQS_ASSERT(lbl, prop, msg)
`define PRQS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### src/prqs_pkg.sv
// Types, constants and helpers shared by the ready-queue scheduler
package prqs_pkg;

  localparam int NUM_LEVELS   = 16;
  localparam int NUM_TASKS    = 32;
  localparam int LVL_W        = $clog2(NUM_LEVELS);
  localparam int TASK_W       = $clog2(NUM_TASKS);
  localparam int CNT_W        = $clog2(NUM_TASKS + 1);
  localparam int LOWEST_LEVEL = NUM_LEVELS - 1;

  // operation kinds
  localparam logic [2:0] K_READY_TAIL = 3'd0;
  localparam logic [2:0] K_CUR_HEAD   = 3'd1;
  localparam logic [2:0] K_SCHED      = 3'd2;
  localparam logic [2:0] K_REMOVE     = 3'd3;
  localparam logic [2:0] K_SET_PRIO   = 3'd4;
  localparam logic [2:0] K_TEMP_PRIO  = 3'd5;
  localparam logic [2:0] K_RESTORE    = 3'd6;

  // result status
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NONE_READY = 2'd1;
  localparam logic [1:0] STAT_NOT_QUEUED = 2'd2;
  localparam logic [1:0] STAT_QUEUED     = 2'd3;

  // task states
  localparam logic [1:0] TS_IDLE    = 2'd0;
  localparam logic [1:0] TS_QUEUED  = 2'd1;
  localparam logic [1:0] TS_ACTIVE  = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] task_id;
    logic [3:0] priority_req;
    logic       holds_mutex;
    logic [3:0] mutex_priority;
  } in_item_t;

  typedef struct packed {
    logic [4:0] current_task;
    logic [4:0] previous_task;
    logic       switched;
    logic [3:0] effective_priority;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [LVL_W-1:0]  eff;
    logic [LVL_W-1:0]  base;
    logic [1:0]        state;
    logic [TASK_W-1:0] nxt;
    logic [TASK_W-1:0] prv;
  } tsk_rec_t;

  typedef struct packed {
    logic [TASK_W-1:0] head;
    logic [TASK_W-1:0] tail;
    logic [CNT_W-1:0]  cnt;
  } lvl_rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LVL, S_SCH_T, S_ENQ, S_UNL, S_P_RD, S_P_WR,
    S_N_RD, S_N_WR, S_C_RD, S_C_WR, S_EFF_RD, S_EFF, S_DONE
  } fsm_t;

  localparam tsk_rec_t TSK_RESET = '{
    eff: LVL_W'(LOWEST_LEVEL), base: LVL_W'(LOWEST_LEVEL), state: TS_IDLE,
    nxt: '0, prv: '0};

  function automatic logic [LVL_W-1:0] clamp_level(logic [3:0] p);
    return (int'(p) > LOWEST_LEVEL) ? LVL_W'(LOWEST_LEVEL) : LVL_W'(p);
  endfunction

endpackage

### src/priority_ready_queue_scheduler.sv
// Top level of the multilevel priority ready-queue scheduler
// One item is handled at a time by a sequencer around two RAMs: a task table
// (priorities, state, queue links) and a level table (head, tail, count). How
// long an item takes is set by the read-modify-write steps on the single read
// port of the task table, which enqueue, remove and schedule need more of than
// set, temporary and restore priority, refused items and a schedule with nothing
// ready. A result may wait in the output register while the next item is taken.
// No clearing pass after reset: per-task valid bits and per-level non-empty
// flags stand in for the reset values.
module priority_ready_queue_scheduler
  import prqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

`include "priority_ready_queue_scheduler_defines.svh"

  fsm_t state, state_next;

  logic [2:0]        kind_r;
  logic [4:0]        tid_r;
  logic [3:0]        req_r;
  logic              holds_r;
  logic [3:0]        ceil_r;
  logic [TASK_W-1:0] tgt;
  logic [LVL_W-1:0]  lv_r;
  tsk_rec_t          trec;
  lvl_rec_t          lrec_r;
  logic [1:0]        status_r;
  logic              switched_r;
  logic [3:0]        eff_r;
  logic [TASK_W-1:0] p_addr, p_val, n_addr, n_val, c_addr;
  logic              do_n, do_c;

  logic [TASK_W-1:0] running_task, last_running;
  logic [LVL_W-1:0]  scan_level;
  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_TASKS-1:0]  tvalid;
  logic              t_rvalid;

  logic              t_we, l_we;
  logic [TASK_W-1:0] t_waddr, t_raddr;
  logic [LVL_W-1:0]  l_waddr, l_raddr;
  tsk_rec_t          t_wdata;
  lvl_rec_t          l_wdata;
  logic [$bits(tsk_rec_t)-1:0] t_rdata;
  logic [$bits(lvl_rec_t)-1:0] l_rdata;

  tsk_rec_t          tmerge;
  lvl_rec_t          lrd;
  logic              scan_found;
  logic [LVL_W-1:0]  scan_lvl;
  logic              tid_ok;
  logic [LVL_W-1:0]  req_c, ceil_c;
  logic              enq_empty, at_head;
  logic              u_head_hit, u_tail_hit, c_need;
  logic [CNT_W-1:0]  u_cnt;

  prqs_ram #(.WIDTH($bits(tsk_rec_t)), .DEPTH(NUM_TASKS)) u_task_ram (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr),
    .rdata(t_rdata)
  );

  prqs_ram #(.WIDTH($bits(lvl_rec_t)), .DEPTH(NUM_LEVELS)) u_lvl_ram (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr),
    .rdata(l_rdata)
  );

  prqs_scan u_scan (
    .nonempty(nonempty), .start(scan_level), .found(scan_found), .level(scan_lvl)
  );

  always_comb begin
    tmerge = t_rvalid ? tsk_rec_t'(t_rdata) : TSK_RESET;
    lrd = lvl_rec_t'(l_rdata);
    if (!nonempty[lv_r]) begin
      lrd.cnt = '0;
    end
    tid_ok     = int'(tid_r) < NUM_TASKS;
    req_c      = clamp_level(req_r);
    ceil_c     = clamp_level(ceil_r);
    enq_empty  = (lrec_r.cnt == '0);
    at_head    = (kind_r == K_CUR_HEAD);
    u_head_hit = (lrec_r.head == tgt);
    u_tail_hit = (lrec_r.tail == tgt);
    u_cnt      = lrec_r.cnt - CNT_W'(1);
    c_need     = (kind_r == K_SCHED) && (tgt != running_task);
  end

  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_RD;
      S_RD: begin
        state_next = S_EFF_RD;
        unique case (kind_r)
          K_READY_TAIL: if (tid_ok && tmerge.state != TS_QUEUED) state_next = S_LVL;
          K_CUR_HEAD:   if (tmerge.state != TS_QUEUED) state_next = S_LVL;
          K_REMOVE:     if (tid_ok && tmerge.state == TS_QUEUED) state_next = S_LVL;
          K_SCHED:      if (scan_found) state_next = S_LVL;
          default:      state_next = S_EFF_RD;
        endcase
      end
      S_LVL: begin
        if (kind_r == K_SCHED) state_next = S_SCH_T;
        else if (kind_r == K_REMOVE) state_next = S_UNL;
        else state_next = S_ENQ;
      end
      S_SCH_T: state_next = S_UNL;
      S_ENQ: begin
        if (enq_empty) state_next = S_EFF_RD;
        else if (at_head) state_next = S_N_RD;
        else state_next = S_P_RD;
      end
      S_UNL: begin
        priority if (!u_head_hit) state_next = S_P_RD;
        else if (!u_tail_hit) state_next = S_N_RD;
        else if (c_need) state_next = S_C_RD;
        else state_next = S_EFF_RD;
      end
      S_P_RD: state_next = S_P_WR;
      S_P_WR: begin
        priority if (do_n) state_next = S_N_RD;
        else if (do_c) state_next = S_C_RD;
        else state_next = S_EFF_RD;
      end
      S_N_RD: state_next = S_N_WR;
      S_N_WR: state_next = do_c ? S_C_RD : S_EFF_RD;
      S_C_RD: state_next = S_C_WR;
      S_C_WR: state_next = S_EFF_RD;
      S_EFF_RD: state_next = S_EFF;
      S_EFF: state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    t_raddr = tgt;
    l_raddr = lv_r;
    t_we    = 1'b0;
    t_waddr = tgt;
    t_wdata = trec;
    l_we    = 1'b0;
    l_waddr = lv_r;
    l_wdata = lrec_r;
    unique case (state)
      S_IDLE: begin
        t_raddr = (in_item.kind == K_CUR_HEAD) ? running_task
                                                : TASK_W'(in_item.task_id);
      end
      S_RD: begin
        l_raddr = (kind_r == K_SCHED) ? scan_lvl : tmerge.eff;
        if (tid_ok && tmerge.state != TS_QUEUED) begin
          t_wdata = tmerge;
          if (kind_r == K_SET_PRIO) begin
            t_we         = 1'b1;
            t_wdata.base = req_c;
            t_wdata.eff  = (holds_r && ceil_c < req_c) ? ceil_c : req_c;
          end else if (kind_r == K_TEMP_PRIO) begin
            t_we        = 1'b1;
            t_wdata.eff = req_c;
          end else if (kind_r == K_RESTORE) begin
            t_we        = 1'b1;
            t_wdata.eff = tmerge.base;
          end
        end
      end
      S_LVL: t_raddr = lrd.head;
      S_ENQ: begin
        t_we          = 1'b1;
        t_wdata.state = TS_QUEUED;
        l_we          = 1'b1;
        l_wdata.cnt   = lrec_r.cnt + CNT_W'(1);
        if (enq_empty) begin
          l_wdata.head = tgt;
          l_wdata.tail = tgt;
        end else if (at_head) begin
          t_wdata.nxt  = lrec_r.head;
          l_wdata.head = tgt;
        end else begin
          t_wdata.prv  = lrec_r.tail;
          l_wdata.tail = tgt;
        end
      end
      S_UNL: begin
        t_we          = 1'b1;
        t_wdata.state = (kind_r == K_SCHED) ? TS_ACTIVE : TS_IDLE;
        l_we          = 1'b1;
        l_wdata.cnt   = u_cnt;
        if (u_head_hit) l_wdata.head = trec.nxt;
        if (u_tail_hit) l_wdata.tail = trec.prv;
      end
      S_P_RD: t_raddr = p_addr;
      S_P_WR: begin
        t_we        = 1'b1;
        t_waddr     = p_addr;
        t_wdata     = tmerge;
        t_wdata.nxt = p_val;
      end
      S_N_RD: t_raddr = n_addr;
      S_N_WR: begin
        t_we        = 1'b1;
        t_waddr     = n_addr;
        t_wdata     = tmerge;
        t_wdata.prv = n_val;
      end
      S_C_RD: t_raddr = c_addr;
      S_C_WR: begin
        t_we          = (tmerge.state == TS_ACTIVE);
        t_waddr       = c_addr;
        t_wdata       = tmerge;
        t_wdata.state = TS_IDLE;
      end
      S_EFF_RD: t_raddr = TASK_W'(tid_r);
      default: ;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_task <= '0;
      last_running <= '0;
      scan_level   <= LVL_W'(LOWEST_LEVEL);
      nonempty     <= '0;
      tvalid       <= '0;
      out_valid    <= 1'b0;
      do_n         <= 1'b0;
      do_c         <= 1'b0;
    end else begin
      state    <= state_next;
      t_rvalid <= tvalid[t_raddr];
      if (t_we) tvalid[t_waddr] <= 1'b1;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r     <= in_item.kind;
            tid_r      <= in_item.task_id;
            req_r      <= in_item.priority_req;
            holds_r    <= in_item.holds_mutex;
            ceil_r     <= in_item.mutex_priority;
            tgt        <= t_raddr;
            status_r   <= STAT_OK;
            switched_r <= 1'b0;
            do_n       <= 1'b0;
            do_c       <= 1'b0;
          end
        end
        S_RD: begin
          trec <= tmerge;
          lv_r <= l_raddr;
          unique case (kind_r)
            K_READY_TAIL, K_SET_PRIO, K_TEMP_PRIO, K_RESTORE: begin
              if (!tid_ok) status_r <= STAT_NOT_QUEUED;
              else if (tmerge.state == TS_QUEUED) status_r <= STAT_QUEUED;
            end
            K_CUR_HEAD: if (tmerge.state == TS_QUEUED) status_r <= STAT_QUEUED;
            K_REMOVE: begin
              if (!tid_ok || tmerge.state != TS_QUEUED) status_r <= STAT_NOT_QUEUED;
            end
            K_SCHED: if (!scan_found) status_r <= STAT_NONE_READY;
            default: ;
          endcase
        end
        S_LVL: begin
          lrec_r <= lrd;
          if (kind_r == K_SCHED) tgt <= lrd.head;
        end
        S_SCH_T: trec <= tmerge;
        S_ENQ: begin
          nonempty[lv_r] <= 1'b1;
          if (lv_r < scan_level) scan_level <= lv_r;
          do_n   <= !enq_empty && at_head;
          n_addr <= lrec_r.head;
          n_val  <= tgt;
          p_addr <= lrec_r.tail;
          p_val  <= tgt;
        end
        S_UNL: begin
          nonempty[lv_r] <= (u_cnt != '0);
          p_addr <= trec.prv;
          p_val  <= trec.nxt;
          n_addr <= trec.nxt;
          n_val  <= trec.prv;
          do_n   <= !u_tail_hit;
          do_c   <= c_need;
          c_addr <= running_task;
          if (kind_r == K_SCHED) begin
            scan_level   <= lv_r;
            last_running <= running_task;
            running_task <= tgt;
            switched_r   <= (tgt != running_task);
          end
        end
        S_EFF: eff_r <= tid_ok ? 4'(tmerge.eff) : 4'd0;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_item.current_task       <= 5'(running_task);
            out_item.previous_task      <= 5'(last_running);
            out_item.switched           <= switched_r;
            out_item.effective_priority <= eff_r;
            out_item.status             <= status_r;
          end
        end
        default: ;
      endcase
    end
  end

  `PRQS_ASSERT(a_sched_level_nonempty, (state == S_LVL && kind_r == K_SCHED) |-> nonempty[lv_r], "schedule picked an empty level")
  `PRQS_ASSERT_NEVER(a_unlink_empty_level, state == S_UNL && lrec_r.cnt == '0, "unlink from a level with no tasks")
  `PRQS_ASSERT(a_sched_runs_pick, (state == S_UNL && kind_r == K_SCHED) |=> (running_task == $past(tgt)), "picked task not made running")

endmodule

### src/prqs_ram.sv
// Generic single-write, single-read RAM with registered read data
module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/prqs_scan.sv
// Wrapping search for the first non-empty level from the scan start
module prqs_scan import prqs_pkg::*; (
  input  logic [NUM_LEVELS-1:0] nonempty,
  input  logic [LVL_W-1:0]      start,
  output logic                  found,
  output logic [LVL_W-1:0]      level
);

  always_comb begin
    logic [LVL_W-1:0] idx;
    found = 1'b0;
    level = start;
    // descending so that the nearest level wins
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      idx = LVL_W'(int'(start) + i);
      if (nonempty[idx]) begin
        found = 1'b1;
        level = idx;
      end
    end
  end

endmodule
